// ===== hdl/rdqb_pkg.sv =====
// Shared types, constants and helpers of the reverse DNS query builder.
package rdqb_pkg;

  localparam int MAX_QUERY_BYTES = 64;
  localparam int MSG_CAP         = 46;
  localparam int SIZE_W          = 10;

  // Message bytes outside the octet labels: header 12, four length bytes,
  // in-addr 8, arpa 5.
  localparam int FIXED_THRU_ARPA = 29;
  localparam int TAIL_BYTES      = 5;

  localparam logic [3:0] HDR_LAST    = 4'd11;
  localparam logic [3:0] INADDR_LAST = 4'd7;
  localparam logic [3:0] ARPA_LAST   = 4'd4;
  localparam logic [3:0] TAIL_LAST   = 4'd4;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // One octet as decimal text, most significant digit at index 0.
  typedef struct packed {
    logic [1:0]      ndig;
    logic [2:0][3:0] dig;
  } dec_t;

  // Classified query, handed from the front to the back end.
  typedef struct packed {
    logic            refused;
    logic [15:0]     query_id;
    logic [3:0][1:0] ndig;
    logic [3:0][2:0][3:0] dig;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic dec_t to_dec(input logic [7:0] v);
    logic [1:0]  h;
    logic [7:0]  r;
    logic [18:0] prod;
    logic [3:0]  t;
    logic [7:0]  u;
    dec_t        d;
    h    = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
    r    = v - (8'(h) * 8'd100);
    prod = 19'(r) * 19'd205;          // r / 10 for r < 100
    t    = prod[14:11];
    u    = r - (8'(t) * 8'd10);
    d    = '0;
    if (v >= 8'd100) begin
      d.ndig   = 2'd3;
      d.dig[0] = {2'b0, h};
      d.dig[1] = t;
      d.dig[2] = u[3:0];
    end else if (v >= 8'd10) begin
      d.ndig   = 2'd2;
      d.dig[0] = t;
      d.dig[1] = u[3:0];
    end else begin
      d.ndig   = 2'd1;
      d.dig[0] = u[3:0];
    end
    return d;
  endfunction

endpackage

// ===== hdl/rdqb_front.sv =====
// Front end: takes commands, converts octets to decimal, decides refusal.
module rdqb_front
  import rdqb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_address,
  input  logic [15:0] in_query_id,
  input  qstat_t      q_stat,
  output logic        q_push,
  output desc_t       q_desc
);

  logic  fe_vld_r, fe_vld_nxt;
  desc_t fe_desc_r, fe_desc_nxt;
  logic  accept;
  dec_t  dec [4];
  logic [SIZE_W-1:0] size_thru_arpa;
  logic  bad_addr;

  assign busy   = fe_vld_r & q_stat.full;
  assign accept = start & ~busy;
  assign q_push = fe_vld_r & ~q_stat.full;
  assign q_desc = fe_desc_r;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      dec[k] = to_dec(in_address[8*k +: 8]);
    end
  end

  assign size_thru_arpa = SIZE_W'(FIXED_THRU_ARPA)
                        + SIZE_W'(dec[0].ndig) + SIZE_W'(dec[1].ndig)
                        + SIZE_W'(dec[2].ndig) + SIZE_W'(dec[3].ndig);

  assign bad_addr = (in_address == 32'h0000_0000) || (in_address == 32'hFFFF_FFFF);

  always_comb begin
    fe_desc_nxt          = fe_desc_r;
    fe_vld_nxt           = fe_vld_r & ~q_push;
    if (accept) begin
      fe_vld_nxt           = 1'b1;
      fe_desc_nxt.query_id = in_query_id;
      for (int k = 0; k < 4; k++) begin
        fe_desc_nxt.ndig[k] = dec[k].ndig;
        fe_desc_nxt.dig[k]  = dec[k].dig;
      end
      fe_desc_nxt.refused = bad_addr
                          || (size_thru_arpa >= SIZE_W'(MAX_QUERY_BYTES))
                          || (size_thru_arpa + SIZE_W'(TAIL_BYTES) > SIZE_W'(MSG_CAP));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fe_vld_r <= 1'b0;
    end else begin
      fe_vld_r <= fe_vld_nxt;
    end
    fe_desc_r <= fe_desc_nxt;
  end

endmodule

// ===== hdl/rdqb_fifo.sv =====
// Short queue of classified queries between the front and back ends.
module rdqb_fifo
  import rdqb_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  desc_t  push_desc,
  input  logic   pop,
  output desc_t  head_desc,
  output qstat_t stat
);

  desc_t             ent_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign head_desc  = ent_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
    if (push) begin
      ent_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

// ===== hdl/rdqb_back.sv =====
// Back end: sequences the query bytes of one classified item per message.
module rdqb_back
  import rdqb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  qstat_t     q_stat,
  input  desc_t      q_desc,
  output logic       q_pop,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_refused
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_HDR    = 3'd1;
  localparam logic [2:0] ST_OCT    = 3'd2;
  localparam logic [2:0] ST_INADDR = 3'd3;
  localparam logic [2:0] ST_ARPA   = 3'd4;
  localparam logic [2:0] ST_TAIL   = 3'd5;
  localparam logic [2:0] ST_REF    = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic [1:0] oct_r, oct_nxt;
  desc_t      cur_r, cur_nxt;

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       last_r, last_nxt;
  logic       refd_r, refd_nxt;
  logic       done;
  logic [1:0] n_cur;
  logic [3:0] digit;

  function automatic logic [7:0] hdr_byte(input logic [15:0] id, input logic [3:0] idx);
    logic [7:0] b;
    b = 8'h00;
    unique case (idx)
      4'd0:    b = id[15:8];
      4'd1:    b = id[7:0];
      4'd2:    b = 8'h01;   // RD
      4'd5:    b = 8'h01;   // QDCOUNT
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] inaddr_char(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd1:    b = "i";
      3'd2:    b = "n";
      3'd3:    b = "-";
      3'd4:    b = "a";
      3'd5:    b = "d";
      3'd6:    b = "d";
      3'd7:    b = "r";
      default: b = 8'd7;    // length byte
    endcase
    return b;
  endfunction

  function automatic logic [7:0] arpa_char(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd1:    b = "a";
      3'd2:    b = "r";
      3'd3:    b = "p";
      3'd4:    b = "a";
      default: b = 8'd4;    // length byte
    endcase
    return b;
  endfunction

  function automatic logic [7:0] tail_byte(input logic [3:0] idx);
    logic [7:0] b;
    unique case (idx)
      4'd2:    b = 8'd12;   // QTYPE PTR
      4'd4:    b = 8'd1;    // QCLASS IN
      default: b = 8'h00;   // root label and high bytes
    endcase
    return b;
  endfunction

  assign n_cur = cur_r.ndig[oct_r];

  always_comb begin
    unique case (cnt_r[1:0])
      2'd2:    digit = cur_r.dig[oct_r][1];
      2'd3:    digit = cur_r.dig[oct_r][2];
      default: digit = cur_r.dig[oct_r][0];
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    oct_nxt   = oct_r;
    cur_nxt   = cur_r;
    valid_nxt = 1'b0;
    byte_nxt  = 8'h00;
    last_nxt  = 1'b0;
    refd_nxt  = 1'b0;
    done      = 1'b0;
    q_pop     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
      end
      ST_HDR: begin
        valid_nxt = 1'b1;
        byte_nxt  = hdr_byte(cur_r.query_id, cnt_r);
        if (cnt_r == HDR_LAST) begin
          cnt_nxt   = '0;
          oct_nxt   = '0;
          state_nxt = ST_OCT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_OCT: begin
        valid_nxt = 1'b1;
        byte_nxt  = (cnt_r == '0) ? {6'b0, n_cur} : (8'h30 | {4'b0, digit});
        if (cnt_r == {2'b0, n_cur}) begin
          cnt_nxt = '0;
          if (oct_r == 2'd3) begin
            state_nxt = ST_INADDR;
          end else begin
            oct_nxt = oct_r + 1'b1;
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_INADDR: begin
        valid_nxt = 1'b1;
        byte_nxt  = inaddr_char(cnt_r[2:0]);
        if (cnt_r == INADDR_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_ARPA;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_ARPA: begin
        valid_nxt = 1'b1;
        byte_nxt  = arpa_char(cnt_r[2:0]);
        if (cnt_r == ARPA_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_TAIL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_TAIL: begin
        valid_nxt = 1'b1;
        byte_nxt  = tail_byte(cnt_r);
        if (cnt_r == TAIL_LAST) begin
          last_nxt = 1'b1;
          done     = 1'b1;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_REF: begin
        valid_nxt = 1'b1;
        last_nxt  = 1'b1;
        refd_nxt  = 1'b1;
        done      = 1'b1;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Load the next item on the final byte so messages run back to back.
    if (state_r == ST_IDLE || done) begin
      if (!q_stat.empty) begin
        q_pop     = 1'b1;
        cur_nxt   = q_desc;
        cnt_nxt   = '0;
        oct_nxt   = '0;
        state_nxt = q_desc.refused ? ST_REF : ST_HDR;
      end else begin
        state_nxt = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      oct_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      oct_r   <= oct_nxt;
      valid_r <= valid_nxt;
    end
    cur_r  <= cur_nxt;
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    refd_r <= refd_nxt;
  end

  assign out_valid   = valid_r;
  assign out_byte    = byte_r;
  assign out_last    = last_r;
  assign out_refused = refd_r;

endmodule

// ===== hdl/reverse_dns_query_builder_unit.sv =====
// Top level of the reverse DNS (PTR) query builder.
// A command (start while busy is low) carries an IPv4 address and a query id;
// the block answers with the bytes of an in-addr.arpa PTR query, one byte per
// cycle while out_valid is high, out_last on the final byte. A message is
// 38 to 46 bytes; a refused address (zero, all ones, or over the size limit)
// gives a single byte with out_refused and out_last set. The receiver cannot
// stall: bytes leave on consecutive cycles and messages follow each other
// without a gap while items are queued. Up to three commands are held (front
// register plus a two-entry queue), so busy rises only when that backlog is
// full. From an idle sequencer, a command passes the front register, the queue
// and the sequencer state register before its first byte leaves the output.
module reverse_dns_query_builder_unit
  import rdqb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_address,
  input  logic [15:0] in_query_id,
  output logic        out_valid,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic        out_refused
);

  qstat_t q_stat;
  logic   q_push, q_pop;
  desc_t  push_desc, head_desc;

  rdqb_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_address  (in_address),
    .in_query_id (in_query_id),
    .q_stat      (q_stat),
    .q_push      (q_push),
    .q_desc      (push_desc)
  );

  rdqb_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (push_desc),
    .pop       (q_pop),
    .head_desc (head_desc),
    .stat      (q_stat)
  );

  rdqb_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_stat      (q_stat),
    .q_desc      (head_desc),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_byte    (out_byte),
    .out_last    (out_last),
    .out_refused (out_refused)
  );

endmodule

// ===== verif/reverse_dns_query_builder_unit_checker.sv =====
// Checker: predicts PTR query bytes per accepted command and compares the byte stream.
module reverse_dns_query_builder_unit_checker
  import rdqb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [31:0] in_address,
  input  logic [15:0] in_query_id,
  input  logic        out_valid,
  input  logic [7:0]  out_byte,
  input  logic        out_last,
  input  logic        out_refused,
  output int          fail_count,
  output int          pending,
  output int          n_commands,
  output int          n_built,
  output int          n_refused
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] FLAGS_RD    = 8'h01;
  localparam logic [7:0] QDCOUNT_LO  = 8'h01;
  localparam logic [7:0] ROOT_LABEL  = 8'h00;
  localparam logic [7:0] QTYPE_PTR   = 8'd12;
  localparam logic [7:0] QCLASS_IN   = 8'h01;
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [31:0] BROADCAST  = 32'hFFFF_FFFF;
  localparam string INADDR_TEXT      = "in-addr";
  localparam string ARPA_TEXT        = "arpa";

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       refused;
  } qbyte_t;

  qbyte_t     expected_bytes[$];
  logic [7:0] query_msg[$];

  function automatic void append_msg_byte(input logic [7:0] b);
    query_msg = {query_msg, b};
  endfunction

  function automatic void expect_byte(input logic [7:0] data, input logic last,
                                      input logic refused);
    qbyte_t e;
    e.data    = data;
    e.last    = last;
    e.refused = refused;
    expected_bytes = {expected_bytes, e};
  endfunction

  // Appends one length-prefixed label unless it would break the size limit.
  function automatic bit add_label(input logic [7:0] text[7], input int len);
    int sz;
    sz = query_msg.size();
    if (sz + 1 + len >= MAX_QUERY_BYTES || sz + 1 + len > MSG_CAP) return 0;
    append_msg_byte(8'(len));
    for (int j = 0; j < len; j++) append_msg_byte(text[j]);
    return 1;
  endfunction

  task automatic predict_query(input logic [31:0] addr, input logic [15:0] id);
    logic [7:0] text[7];
    logic [7:0] v;
    int         n;
    bit         ok;
    ok = (addr != 32'd0) && (addr != BROADCAST);
    query_msg.delete();
    if (ok) begin
      query_msg = '{id[15:8], id[7:0], FLAGS_RD, 8'h00, 8'h00, QDCOUNT_LO,
                    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      // last wire octet goes first in the name
      for (int i = 0; i < 4 && ok; i++) begin
        v = addr[8*i +: 8];
        n = 0;
        if (v >= 100) begin
          text[n] = ASCII_ZERO + v / 100; n++;
        end
        if (v >= 10) begin
          text[n] = ASCII_ZERO + (v / 10) % 10; n++;
        end
        text[n] = ASCII_ZERO + v % 10; n++;
        ok = add_label(text, n);
      end
      if (ok) begin
        for (int j = 0; j < 7; j++) text[j] = INADDR_TEXT[j];
        ok = add_label(text, 7);
      end
      if (ok) begin
        for (int j = 0; j < 4; j++) text[j] = ARPA_TEXT[j];
        ok = add_label(text, 4);
      end
      if (ok && query_msg.size() + TAIL_BYTES > MSG_CAP) ok = 0;
    end
    if (ok) begin
      append_msg_byte(ROOT_LABEL);
      append_msg_byte(8'h00);
      append_msg_byte(QTYPE_PTR);
      append_msg_byte(8'h00);
      append_msg_byte(QCLASS_IN);
      foreach (query_msg[k])
        expect_byte(query_msg[k], k == query_msg.size() - 1, 1'b0);
      n_built++;
    end else begin
      expect_byte(8'h00, 1'b1, 1'b1);
      n_refused++;
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
    n_commands = 0;
    n_built    = 0;
    n_refused  = 0;
  end

  always @(posedge clk) begin
    qbyte_t exp_b;
    if (rst_n) begin
      if (start && !busy) begin
        predict_query(in_address, in_query_id);
        n_commands++;
      end
      if (out_valid) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h last=%0b refused=%0b",
                                    out_byte, out_last, out_refused));
        end else begin
          exp_b = expected_bytes.pop_front();
          if (out_byte !== exp_b.data)
            report_mismatch($sformatf("byte %02h, expected %02h", out_byte, exp_b.data));
          if (out_last !== exp_b.last)
            report_mismatch($sformatf("last %0b, expected %0b", out_last, exp_b.last));
          if (out_refused !== exp_b.refused)
            report_mismatch($sformatf("refused %0b, expected %0b",
                                      out_refused, exp_b.refused));
        end
      end
      pending = expected_bytes.size();
    end
  end

endmodule

// ===== verif/reverse_dns_query_builder_unit_tb.sv =====
// Testbench top: drives address/id commands into the PTR query builder and gives the verdict.
module reverse_dns_query_builder_unit_tb;
  import rdqb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM   = 190;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYC  = 60;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] in_address;
  logic [15:0] in_query_id;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        out_refused;

  int fail_count, pending, n_commands, n_built, n_refused;
  int idle_cycles;

  reverse_dns_query_builder_unit uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_address(in_address), .in_query_id(in_query_id),
    .out_valid(out_valid), .out_byte(out_byte),
    .out_last(out_last), .out_refused(out_refused)
  );

  reverse_dns_query_builder_unit_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_address(in_address), .in_query_id(in_query_id),
    .out_valid(out_valid), .out_byte(out_byte),
    .out_last(out_last), .out_refused(out_refused),
    .fail_count(fail_count), .pending(pending), .n_commands(n_commands),
    .n_built(n_built), .n_refused(n_refused)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a stretch with no transaction on either side ends the run.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [7:0] rand_octet();
    case ($urandom_range(0, 2))
      0:       return 8'($urandom_range(0, 9));
      1:       return 8'($urandom_range(10, 99));
      default: return 8'($urandom_range(100, 255));
    endcase
  endfunction

  function automatic logic [31:0] rand_address();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? 32'd0 : 32'hFFFF_FFFF;
      1, 2, 3,
      4, 5:    return {rand_octet(), rand_octet(), rand_octet(), rand_octet()};
      default: return $urandom;
    endcase
  endfunction

  // Holds start until the command is taken; leaves on the following falling edge.
  task automatic send_command(input logic [31:0] addr, input logic [15:0] id);
    start       <= 1'b1;
    in_address  <= addr;
    in_query_id <= id;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic idle_for(input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  initial begin
    logic [31:0] directed_addr[$];
    logic [15:0] directed_id[$];
    int          gap;
    int          drain;

    idle_cycles = 0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_address  = '0;
    in_query_id = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // zero and broadcast refusals, one/two/three digit octets, id extremes
    directed_addr = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFE,
                      32'h0101_0101, 32'h0A14_1E28, 32'h6463_0900, 32'hFFFF_FFFF,
                      32'h8000_0000, 32'h7FFF_FFFF, 32'hC0A8_0101, 32'h0909_0909,
                      32'h6464_6464, 32'hFF00_FF00, 32'h00FF_00FF, 32'h0000_0000,
                      32'hAAAA_AAAA, 32'h5555_5555, 32'h0A0A_0A0A, 32'hC8C7_6362};
    directed_id   = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555,
                      16'h1234, 16'h8001, 16'h7FFE, 16'hFFFF, 16'h0001, 16'h0100,
                      16'hABCD, 16'h0000, 16'hFFFF, 16'h5A5A, 16'h0F0F, 16'hF0F0,
                      16'hFFFF, 16'h0000};
    foreach (directed_addr[i]) begin
      send_command(directed_addr[i], directed_id[i]);
      idle_for(i < 8 ? 0 : $urandom_range(0, 3));
    end

    // let the backlog drain fully before the random traffic
    start <= 1'b0;
    while (pending != 0) @(negedge clk);

    for (int i = 0; i < N_RANDOM; i++) begin
      send_command(rand_address(), 16'($urandom));
      if (i == 100) begin
        start <= 1'b0;
        while (pending != 0) @(negedge clk);
      end
      gap = (i >= 40 && i < 80) ? 0 : $urandom_range(0, 3);
      idle_for(gap);
    end
    start <= 1'b0;

    while (pending != 0) @(negedge clk);
    drain = 0;
    while (drain < DRAIN_CYC) begin
      @(negedge clk);
      drain++;
    end

    $display("Sent %0d commands: %0d PTR queries built, %0d refusals.",
             n_commands, n_built, n_refused);
    $display("Stimulus mixed 1/2/3-digit octets, zero/broadcast and random ids.");
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
